>>> rtl/rbpe_pkg.sv
package rbpe_pkg;

    typedef struct packed {
        logic [7:0] count;
        logic [7:0] value;
        logic       last;
    } t_pair;

    localparam int unsigned BYTE_W = 8;

endpackage

>>> rtl/rbpe_front.sv
module rbpe_front #(
    parameter int unsigned MAX_RUN = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_in_byte,
    input  logic                i_block_end,
    output logic                o_full,
    input  logic                i_q_full,
    output logic                o_q_push,
    output rbpe_pkg::t_pair     o_q_wdata
);

    localparam logic [rbpe_pkg::BYTE_W-1:0] MAX_LEN = rbpe_pkg::BYTE_W'(MAX_RUN);

    logic [7:0]       r_val, n_val;
    logic [7:0]       r_len, n_len;
    logic             r_pend_v, n_pend_v;
    rbpe_pkg::t_pair  r_pend, n_pend;

    logic             accept;
    logic             extend;
    logic             close_run;
    logic [7:0]       run_len;
    logic [7:0]       run_val;
    rbpe_pkg::t_pair  close_pair;
    rbpe_pkg::t_pair  end_pair;

    assign o_full = r_pend_v || i_q_full;
    assign accept = i_push && !o_full;

    assign extend    = (r_len != 8'd0) && (i_in_byte == r_val) && (r_len < MAX_LEN);
    assign close_run = (r_len != 8'd0) && !extend;
    assign run_len   = extend ? (r_len + 8'd1) : 8'd1;
    assign run_val   = extend ? r_val : i_in_byte;

    always_comb begin
        close_pair.count = r_len;
        close_pair.value = r_val;
        close_pair.last  = 1'b0;
        end_pair.count   = run_len;
        end_pair.value   = run_val;
        end_pair.last    = 1'b1;
    end

    always_comb begin
        n_val     = r_val;
        n_len     = r_len;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        o_q_push  = 1'b0;
        o_q_wdata = r_pend;
        if (r_pend_v) begin
            if (!i_q_full) begin
                o_q_push = 1'b1;
                n_pend_v = 1'b0;
            end
        end else if (accept) begin
            n_val = run_val;
            n_len = i_block_end ? 8'd0 : run_len;
            if (close_run) begin
                o_q_push  = 1'b1;
                o_q_wdata = close_pair;
                if (i_block_end) begin
                    n_pend_v = 1'b1;
                    n_pend   = end_pair;
                end
            end else if (i_block_end) begin
                o_q_push  = 1'b1;
                o_q_wdata = end_pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val    <= 8'd0;
            r_len    <= 8'd0;
            r_pend_v <= 1'b0;
        end else begin
            r_val    <= n_val;
            r_len    <= n_len;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    a_end_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_block_end) |=> (r_len == 8'd0))
        else $error("run not closed at block end");

    a_pend_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pend_v) |-> $past(accept && i_block_end))
        else $error("pending pair without block end");

endmodule

>>> rtl/rbpe_queue.sv
module rbpe_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rbpe_pkg::t_pair  i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output rbpe_pkg::t_pair  o_rdata,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rbpe_pkg::t_pair r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : (r_wr + AW'(1));
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : (r_rd + AW'(1));
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue count overflow");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

endmodule

>>> rtl/rbpe_back.sv
module rbpe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rbpe_pkg::t_pair  i_q_rdata,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);

    logic             r_valid, n_valid;
    logic             r_phase, n_phase;
    rbpe_pkg::t_pair  r_pair, n_pair;
    logic             take;

    assign o_empty    = !r_valid;
    assign o_out_byte = r_phase ? r_pair.value : r_pair.count;
    assign o_out_last = r_phase && r_pair.last;

    // next pair is needed when idle or when the value word leaves
    assign take    = !r_valid || (i_pop && r_phase);
    assign o_q_pop = take && !i_q_empty;

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        n_pair  = r_pair;
        if (r_valid && i_pop && !r_phase) begin
            n_phase = 1'b1;
        end else if (take) begin
            n_phase = 1'b0;
            n_valid = !i_q_empty;
            n_pair  = i_q_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair <= n_pair;
    end

    a_value_follows_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_pop && !r_phase) |=> (r_valid && r_phase && $stable(r_pair)))
        else $error("value word did not follow count word");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_pair.count != 8'd0))
        else $error("zero run count");

endmodule

>>> rtl/rle_byte_pair_encoder_unit.sv
// Channel  | Direction | Handshake              | Payload
// input    | in        | push / full            | i_in_byte, i_block_end
// result   | out       | empty / pop            | o_out_byte, o_out_last
//
// A byte is taken whenever push is high and full is low; a closed run leaves as two words, count then value.
// Sustained rate is set by the byte-wide result port, which emits each pair as two words.
// A byte that closes a run at block end queues two pairs; full is high one cycle,
// longer while the pair queue is full.
// Reset is synchronous and clears run state, pair queue and output stage.
// Result stalls back up through the pair queue (QDEPTH pairs) before full rises.
module rle_byte_pair_encoder_unit #(
    parameter int unsigned MAX_RUN = 255,
    parameter int unsigned QDEPTH  = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_block_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    rbpe_pkg::t_pair  q_wdata;
    rbpe_pkg::t_pair  q_rdata;

    rbpe_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_byte   (i_in_byte),
        .i_block_end (i_block_end),
        .o_full      (full),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_wdata   (q_wdata)
    );

    rbpe_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    rbpe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_rdata  (q_rdata),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_RUN     = 255;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 40;

    typedef struct packed {
        logic [rbpe_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_word;

    logic                        i_clk;
    logic                        i_rst_n     = 1'b0;
    logic                        push        = 1'b0;
    logic                        full;
    logic [rbpe_pkg::BYTE_W-1:0] i_in_byte   = '0;
    logic                        i_block_end = 1'b0;
    logic                        empty;
    logic                        pop         = 1'b0;
    logic [rbpe_pkg::BYTE_W-1:0] o_out_byte;
    logic                        o_out_last;

    rle_byte_pair_encoder_unit #(
        .MAX_RUN(MAX_RUN)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .i_block_end(i_block_end),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    // encoder state as predicted
    logic [rbpe_pkg::BYTE_W-1:0] run_val = '0;
    logic [7:0]                  run_len = '0;
    t_word                       expected_words[$];

    int          mismatches   = 0;
    int unsigned cycle_cnt    = 0;
    bit          tx_busy_only = 1'b0;
    bit          rx_busy_only = 1'b0;
    int          rx_hold_req  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d words outstanding", $realtime, expected_words.size());
            $display("rle_byte_pair_encoder_unit: mismatch");
            $finish;
        end
    end

    task automatic queue_pair(input logic [7:0] cnt, input logic [rbpe_pkg::BYTE_W-1:0] val,
                              input logic last);
        t_word w;
        w.data = cnt;
        w.last = 1'b0;
        expected_words.push_back(w);
        w.data = val;
        w.last = last;
        expected_words.push_back(w);
    endtask

    task automatic encode_byte(input logic [rbpe_pkg::BYTE_W-1:0] b, input logic e);
        if (run_len != 0 && b == run_val && run_len < MAX_RUN) begin
            run_len = run_len + 8'd1;
        end else begin
            if (run_len != 0) begin
                queue_pair(run_len, run_val, 1'b0);
            end
            run_val = b;
            run_len = 8'd1;
        end
        if (e) begin
            queue_pair(run_len, run_val, 1'b1);
            run_len = 8'd0;
        end
    endtask

    task automatic send_byte(input logic [rbpe_pkg::BYTE_W-1:0] b, input logic e);
        int gap;
        gap = tx_busy_only ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_in_byte   <= b;
        i_block_end <= e;
        do @(posedge i_clk); while (full);
        encode_byte(b, e);
    endtask

    task automatic pause_until_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    // result side: random stall before each word, honors a requested hold-off
    initial begin
        int    stall;
        t_word want;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                stall = rx_busy_only ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word: expected none, actual byte %h last %b",
                         $realtime, o_out_byte, o_out_last);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t out_byte: expected %h, actual %h",
                             $realtime, want.data, o_out_byte);
                    mismatches++;
                end
                if (o_out_last !== want.last) begin
                    $display("%0t out_last: expected %b, actual %b",
                             $realtime, want.last, o_out_last);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_single_byte_blocks();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_short_runs();
        // run closed by a different byte, then a single at block end
        send_byte(8'hA5, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        // block end byte closes an open run: two pairs at once
        send_byte(8'h11, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
        // block end byte extends the run
        send_byte(8'h33, 1'b0);
        send_byte(8'h33, 1'b1);
        // same value as last run, but no run open
        send_byte(8'h33, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_run_cap();
        // full-length run, then an equal byte at block end starts a new run
        tx_busy_only = 1'b1;
        repeat (MAX_RUN) send_byte(8'h7E, 1'b0);
        send_byte(8'h7E, 1'b1);
        tx_busy_only = 1'b0;
    endtask

    task automatic test_backpressure();
        rx_hold_req  = 300;
        tx_busy_only = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_byte(8'(i * 7 + 3), (i % 3) == 2);
        end
        tx_busy_only = 1'b0;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 6; i++) begin
            send_byte(8'($urandom_range(0, 3)), i == 5);
        end
        pause_until_drained();
        for (int i = 0; i < 6; i++) begin
            send_byte(8'($urandom_range(0, 3)), i == 5);
        end
    endtask

    task automatic test_random_blocks(input int n_items);
        int                          sent;
        int                          blen;
        int                          rep_pct;
        int                          rep_choices[4];
        logic [rbpe_pkg::BYTE_W-1:0] b;
        sent        = 0;
        b           = '0;
        rep_choices = '{0, 50, 85, 97};
        while (sent < n_items) begin
            tx_busy_only = (sent >= n_items / 2);
            rx_busy_only = ((sent / (n_items / 4)) % 2) == 1;
            rep_pct      = rep_choices[$urandom_range(0, 3)];
            blen         = $urandom_range(1, 10);
            for (int i = 0; i < blen; i++) begin
                if (i == 0 || $urandom_range(0, 99) >= rep_pct) begin
                    b = 8'($urandom_range(0, 255));
                end
                send_byte(b, i == blen - 1);
                sent++;
            end
        end
        tx_busy_only = 1'b0;
        rx_busy_only = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_byte_blocks();
        test_short_runs();
        test_run_cap();
        test_backpressure();
        test_drain_pause();
        test_random_blocks(40);

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $display("%0t %0d expected words never arrived", $realtime, expected_words.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("rle_byte_pair_encoder_unit: match");
        end else begin
            $display("rle_byte_pair_encoder_unit: mismatch");
        end
        $finish;
    end

endmodule

>>> rle_byte_pair_encoder_unit.f
rtl/rbpe_pkg.sv
rtl/rbpe_front.sv
rtl/rbpe_queue.sv
rtl/rbpe_back.sv
rtl/rle_byte_pair_encoder_unit.sv
tb/tb_top.sv
